[src/positional_ordered_list_unit_defines.svh]
// Assertion helpers for the ordered list unit; empty in synthesis builds.
`ifndef POSITIONAL_ORDERED_LIST_UNIT_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define POL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define POL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define POL_ASSERT_IMP(label, ante, cons, msg)
`define POL_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

[src/pol_pkg.sv]
package pol_pkg;

  localparam int VAL_W   = 32;
  localparam int POS_W   = 8;
  localparam int REQ_W   = 3;
  localparam int ST_W    = 3;
  localparam int CNT_W   = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_HEAD = 3'd0,
    REQ_INS_TAIL = 3'd1,
    REQ_INS_POS  = 3'd2,
    REQ_DEL_HEAD = 3'd3,
    REQ_DEL_TAIL = 3'd4,
    REQ_DEL_POS  = 3'd5,
    REQ_TRAVERSE = 3'd6
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_BADPOS = 3'd3,
    ST_RANGE  = 3'd4
  } status_t;

  // Operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] idx;    // target slot; on rotate, the last occupied slot
    logic [VAL_W-1:0] value;  // value to insert
  } cell_cmd_t;

endpackage

[src/pol_cell.sv]
module pol_cell #(
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  pol_pkg::cell_cmd_t       cmd,
  input  logic [pol_pkg::VAL_W-1:0] left_val,
  input  logic [pol_pkg::VAL_W-1:0] right_val,
  input  logic [pol_pkg::VAL_W-1:0] head_val,
  output logic [pol_pkg::VAL_W-1:0] val,
  output logic [pol_pkg::VAL_W-1:0] tap
);
  import pol_pkg::*;

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;

  // Pick the next value from the neighbors
  always_comb begin
    val_nxt = val_r;
    case (cmd.op)
      CELL_INS: begin
        if (MY_IDX > cmd.idx) begin
          val_nxt = left_val;
        end else if (MY_IDX == cmd.idx) begin
          val_nxt = cmd.value;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= cmd.idx) begin
          val_nxt = right_val;
        end
      end
      CELL_ROT: begin
        if (MY_IDX == cmd.idx) begin
          val_nxt = head_val;
        end else begin
          val_nxt = right_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  // Offer the value when this cell is the one addressed
  assign tap = (MY_IDX == cmd.idx) ? val_r : '0;

endmodule

[src/positional_ordered_list_unit.sv]
// Bounded ordered list of signed 32-bit values held in a chain of CAPACITY cells.
// Input channel (in_*): one request per beat; in_tuser carries the request kind,
// in_tdata the value to insert and the 1-based position.
// Result channel (out_*): status, removed or traversed value and element count in
// out_tdata; out_tlast marks the final beat of a request.
// Insert and delete requests complete at the accepting edge: every cell shifts toward
// or away from the addressed slot at the same clock edge, and the single result is
// registered and shown the cycle after acceptance. A new request may be accepted each
// cycle while the output register is free or being drained.
// In a traversal the accepting edge only enters the traversal; then the chain rotates
// by one cell per cycle while the output register is free, the head cell feeding the
// output register at each rotation, and after N beats of an N-element list it is back
// in its original order.
// Requests are held off during a traversal.
// A stalled receiver freezes the output register, the chain and the traversal.
// Reset (rst_n low, synchronous) empties the list and drops any pending beat;
// the cell contents are not cleared, empty slots are never read.
module positional_ordered_list_unit #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] value_in, [39:32] position
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [2:0] status, [34:3] value_out, [39:35] list_count
  output logic        out_tlast
);
  import pol_pkg::*;

  `include "positional_ordered_list_unit_defines.svh"

  localparam int LEN_W = $clog2(CAPACITY + 1);

  typedef enum logic {S_IDLE, S_TRAV} state_t;

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;
  logic              out_last_r, out_last_nxt;

  cell_cmd_t         cmd;
  logic [VAL_W-1:0]  vals [CAPACITY];
  logic [VAL_W-1:0]  taps [CAPACITY];
  logic [VAL_W-1:0]  tap_or;

  logic              acc;
  logic              out_free;
  logic              trav_step;
  logic              full;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  len8;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign acc       = in_tvalid && in_tready;
  assign trav_step = (state_r == S_TRAV) && out_free;
  assign full      = (len_r == LEN_W'(CAPACITY));
  assign pos       = in_tdata[39:32];
  assign len8      = POS_W'(len_r);

  // Chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_v;
    logic [VAL_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = cmd.value;
    end else begin : g_mid
      assign left_v = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_lastc
      assign right_v = vals[i];
    end else begin : g_inner
      assign right_v = vals[i+1];
    end
    pol_cell #(.INDEX(i)) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (vals[0]),
      .val       (vals[i]),
      .tap       (taps[i])
    );
  end

  // Collect the addressed cell's value
  always_comb begin
    tap_or = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      tap_or = tap_or | taps[k];
    end
  end

  // Decode requests and step traversals
  always_comb begin
    cmd            = '{op: CELL_HOLD, idx: '0, value: in_tdata[31:0]};
    state_nxt      = state_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    if (acc) begin
      out_valid_nxt  = 1'b1;
      out_last_nxt   = 1'b1;
      out_value_nxt  = '0;
      out_status_nxt = ST_OK;
      case (req_t'(in_tuser))
        REQ_INS_HEAD: begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            cmd.op  = CELL_INS;
            cmd.idx = '0;
            len_nxt = len_r + LEN_W'(1);
          end
        end
        REQ_INS_TAIL: begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            cmd.op  = CELL_INS;
            cmd.idx = len8;
            len_nxt = len_r + LEN_W'(1);
          end
        end
        REQ_INS_POS: begin
          if (pos == '0) begin
            out_status_nxt = ST_BADPOS;
          end else if (full) begin
            out_status_nxt = ST_FULL;
          end else if ({1'b0, pos} > ({1'b0, len8} + 9'd1)) begin
            out_status_nxt = ST_RANGE;
          end else begin
            cmd.op  = CELL_INS;
            cmd.idx = pos - POS_W'(1);
            len_nxt = len_r + LEN_W'(1);
          end
        end
        REQ_DEL_HEAD: begin
          cmd.idx = '0;
          if (len_r == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            cmd.op        = CELL_DEL;
            out_value_nxt = tap_or;
            len_nxt       = len_r - LEN_W'(1);
          end
        end
        REQ_DEL_TAIL: begin
          cmd.idx = len8 - POS_W'(1);
          if (len_r == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            cmd.op        = CELL_DEL;
            out_value_nxt = tap_or;
            len_nxt       = len_r - LEN_W'(1);
          end
        end
        REQ_DEL_POS: begin
          cmd.idx = pos - POS_W'(1);
          if (len_r == '0) begin
            out_status_nxt = ST_EMPTY;
          end else if (pos == '0) begin
            out_status_nxt = ST_BADPOS;
          end else if (pos > len8) begin
            out_status_nxt = ST_RANGE;
          end else begin
            cmd.op        = CELL_DEL;
            out_value_nxt = tap_or;
            len_nxt       = len_r - LEN_W'(1);
          end
        end
        REQ_TRAVERSE: begin
          if (len_r == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_TRAV;
            cnt_nxt       = '0;
          end
        end
        default: out_status_nxt = ST_OK;
      endcase
      out_count_nxt = CNT_W'(len_nxt);
    end else if (trav_step) begin
      // Emit the head and rotate the occupied cells by one
      cmd.op         = CELL_ROT;
      cmd.idx        = len8 - POS_W'(1);
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_value_nxt  = vals[0];
      out_count_nxt  = CNT_W'(len_r);
      out_last_nxt   = (cnt_r + LEN_W'(1)) == len_r;
      cnt_nxt        = cnt_r + LEN_W'(1);
      if ((cnt_r + LEN_W'(1)) == len_r) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_value_r, out_status_r};
  assign out_tlast  = out_last_r;

  `POL_ASSERT_NXT(a_req_beat, acc && (in_tuser != REQ_TRAVERSE), out_valid_r, "request without result beat")
  `POL_ASSERT_IMP(a_nonlast_trav, out_valid_r && !out_last_r, state_r == S_TRAV, "non-final beat outside traversal")
  `POL_ASSERT_NXT(a_ins_grow, acc && (in_tuser == REQ_INS_HEAD) && !full, len_r == $past(len_r) + LEN_W'(1), "insert did not grow list")
  `POL_ASSERT_IMP(a_len_bound, state_r == S_TRAV, (len_r != '0) && (cnt_r < len_r), "traversal count out of range")

endmodule
